### rtl/wis_pkg.sv
// Shared types and constants for the weighted index sampler.
// No dependencies.
package wis_pkg;

  // Running sums are kept at a fixed 24 bits and saturate.
  localparam int unsigned SUM_W   = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Width of the index field in a result item.
  localparam int unsigned IDX_W = 8;

  // Operation codes carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for an item
    ST_CHK0,   // entry 0 read back, first compare
    ST_SRCH,   // one binary-search step per cycle
    ST_DONE    // result held until the output register frees up
  } wis_state_t;

endpackage

### rtl/weighted_index_sampler.sv
// Weighted index sampler: inverse-CDF discrete sampling over a table of running sums.
// Depends on wis_pkg.
//
// Usage:
//   Input items arrive on in_* (tvalid/tready). in_tuser[0] is the operation
//   (0 = load a weight, 1 = draw), in_tuser[1] flags the first weight of a new
//   table. A load appends |weight| to the running sum and stores the sum in the
//   table memory; it produces no result item.
//   A draw returns one result item on out_*: the index of the first entry whose
//   cum * RMAX exceeds r * total (entry 0 also on a tie; RMAX = 2^RANDOM_BITS - 1),
//   clamped to the last entry. With an all-zero table the index is 0 for r = 0, else
//   the last entry. A draw on an empty table gives out_tuser = 1 (no table), index 0.
// Draw sequence:
//   accept and multiply, check of entry 0, one search step per memory read, then
//   the result hand-off; an empty or all-zero table goes straight to the hand-off.
//   No new item is taken until a draw is through. The single read port of the
//   table memory sets the pace of the search.
// Reset: entry count and total clear, so the table is empty; the memory itself
//   is not cleared, entries past the count never reach a compare.
// Stall: the result sits in an output register; while it waits, loads and draws
//   are still taken. A second draw finishes its search and then holds, with
//   in_tready low, until the previous result has been taken.
module weighted_index_sampler
  import wis_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [WEIGHT_BITS-1:0] weight (signed), next RANDOM_BITS: random_value, zero fill
  input  logic [((WEIGHT_BITS+RANDOM_BITS+7)/8)*8-1:0] in_tdata,
  // [0] operation, [1] first_weight
  input  logic [1:0]           in_tuser,

  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] sample_index
  output logic [IDX_W-1:0]     out_tdata,
  // [0] no_table
  output logic [0:0]           out_tuser
);

  localparam int unsigned ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ADD_W  = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;
  localparam int unsigned PROD_W = SUM_W + RANDOM_BITS;

  // Table memory, one write and one registered read per cycle.
  logic [SUM_W-1:0]  mem [MAX_ENTRIES];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control and datapath registers.
  wis_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [PROD_W-1:0] target_r, target_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0]  res_idx_r, res_idx_nxt;
  logic              res_none_r, res_none_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_none_r, out_none_nxt;

  // Input field decode.
  logic                   in_acc;
  logic                   in_op;
  logic                   in_first;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [RANDOM_BITS-1:0] in_rand;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser[0];
  assign in_first  = in_tuser[1];
  assign in_weight = in_tdata[WEIGHT_BITS-1:0];
  assign in_rand   = in_tdata[WEIGHT_BITS +: RANDOM_BITS];

  // Load path: magnitude, saturating add, table append.
  logic [WEIGHT_BITS-1:0] mag;
  logic [CNT_W-1:0]       base_cnt;
  logic [SUM_W-1:0]       base_tot;
  logic [ADD_W-1:0]       sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic                   load_ok;

  assign mag      = in_weight[WEIGHT_BITS-1] ? (~in_weight + 1'b1) : in_weight;
  assign base_cnt = in_first ? '0 : count_r;
  assign base_tot = in_first ? '0 : total_r;
  assign sum_wide = ADD_W'(base_tot) + ADD_W'(mag);
  assign sum_sat  = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign load_ok  = in_acc && (in_op == OP_LOAD) && (base_cnt < CNT_W'(MAX_ENTRIES));

  assign wr_en   = load_ok;
  assign wr_addr = base_cnt[ADDR_W-1:0];
  assign wr_data = sum_sat;

  // Search compare: cum * RMAX > r * total, with cum * RMAX as shift minus cum.
  logic [PROD_W-1:0] cum_scaled;
  logic              cum_gt;
  logic              cum_ge;
  logic [CNT_W-1:0]  last_idx;
  logic [CNT_W-1:0]  step_lo;
  logic [CNT_W-1:0]  step_hi;
  logic [CNT_W:0]    mid_sum;
  logic              step_more;
  logic [CNT_W-1:0]  step_res;

  assign cum_scaled = {rd_data_r, {RANDOM_BITS{1'b0}}} - PROD_W'(rd_data_r);
  assign cum_gt     = cum_scaled > target_r;
  // entry 0 wins on a tie as well
  assign cum_ge     = cum_scaled >= target_r;
  assign last_idx   = count_r - 1'b1;

  // Bounds after this cycle's compare; the check of entry 0 opens [1, count).
  always_comb begin
    step_lo = lo_r;
    step_hi = hi_r;
    if (state_r == ST_CHK0) begin
      step_lo = CNT_W'(1);
      step_hi = count_r;
    end else if (cum_gt) begin
      step_hi = CNT_W'(mid_r);
    end else begin
      step_lo = CNT_W'(mid_r) + 1'b1;
    end
  end

  assign mid_sum   = (CNT_W+1)'(step_lo) + (CNT_W+1)'(step_hi);
  assign step_more = step_lo < step_hi;
  assign step_res  = (step_lo > last_idx) ? last_idx : step_lo;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_DRAW)) begin
          if ((count_r == '0) || (total_r == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHK0;
          end
        end
      end
      ST_CHK0: begin
        if (cum_ge || !step_more) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (!step_more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_idx_nxt   = res_idx_r;
    res_none_nxt  = res_none_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_none_nxt  = out_none_r;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (load_ok) begin
          count_nxt = base_cnt + 1'b1;
          total_nxt = sum_sat;
        end
        if (in_acc && (in_op == OP_DRAW)) begin
          target_nxt   = PROD_W'(in_rand) * PROD_W'(total_r);
          res_none_nxt = (count_r == '0);
          if (count_r == '0) begin
            res_idx_nxt = '0;
          end else if (in_rand == '0) begin
            res_idx_nxt = '0;
          end else begin
            res_idx_nxt = last_idx;  // zero total, nonzero draw
          end
        end
      end
      ST_CHK0, ST_SRCH: begin
        lo_nxt  = step_lo;
        hi_nxt  = step_hi;
        mid_nxt = mid_sum[ADDR_W:1];
        rd_addr = mid_sum[ADDR_W:1];
        if ((state_r == ST_CHK0) && cum_ge) begin
          res_idx_nxt = '0;
        end else begin
          res_idx_nxt = step_res;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_none_nxt  = res_none_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    res_idx_r  <= res_idx_nxt;
    res_none_r <= res_none_nxt;
    out_idx_r  <= out_idx_nxt;
    out_none_r <= out_none_nxt;
  end

  // Index keeps its low bits only.
  logic [CNT_W+IDX_W-1:0] out_idx_ext;
  assign out_idx_ext = {{IDX_W{1'b0}}, out_idx_r};

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_idx_ext[IDX_W-1:0];
  assign out_tuser[0] = out_none_r;

endmodule

### tb/sv/weighted_index_sampler_tb.sv
// Self-checking bench for weighted_index_sampler: directed table, then random load/draw runs.
// Draw results are checked field by field against an in-bench inverse-CDF predictor.
// Depends on wis_pkg and the weighted_index_sampler RTL.
module weighted_index_sampler_tb
  import wis_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_CAP  = 256;
  localparam longint unsigned R_FULL = 64'd65535;   // 2^16 - 1
  localparam int unsigned RAND_ITEMS = 1900;

  // one row of the directed table; fixed_res = 1 means idx/nt are typed in
  typedef struct packed {
    logic        op;
    logic        first;
    logic [15:0] weight;
    logic [15:0] rnd;
    logic        fixed_res;
    logic [7:0]  idx;
    logic        nt;
  } step_row_t;

  // what a draw should return
  typedef struct packed {
    logic       nt;
    logic [7:0] idx;
  } pick_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [15:0] weight (signed), [31:16] random_value
  logic [31:0] in_tdata  = '0;
  // [0] operation, [1] first_weight
  logic [1:0]  in_tuser  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] sample_index
  logic [7:0]  out_tdata;
  // [0] no_table
  logic [0:0]  out_tuser;

  // predictor state: running sums, entry count, total
  logic [23:0] cum_sums [TABLE_CAP];
  int          entry_cnt  = 0;
  logic [23:0] weight_sum = '0;

  pick_t       pending_picks [$];
  int          mismatch_cnt = 0;
  int          items_sent   = 0;
  bit          no_idle      = 1'b0;   // both sides run without gaps
  bit          hold_req     = 1'b0;   // asks the receiver for a long hold-off
  int          hold_left    = 0;

  // Directed part. Typed results cover the obvious ones: empty table, single entry,
  // all-zero table, r = 0, clamp at r = max. The rest go through the predictor.
  localparam step_row_t DIRECTED [25] = '{
    // draws straight after reset hit the empty table
    '{OP_DRAW, 1'b0, 16'h1234, 16'h0000, 1'b1, 8'd0, 1'b1},
    '{OP_DRAW, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 8'd0, 1'b1},
    // load with no first flag on an empty table lands at index 0
    '{OP_LOAD, 1'b0, 16'h0005, 16'hA5A5, 1'b0, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd0, 1'b0},
    // all-zero table: r = 0 gives 0, anything else the last entry
    '{OP_LOAD, 1'b1, 16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h0001, 1'b1, 8'd2, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd2, 1'b0},
    // weight extremes, negative values folded to magnitude
    '{OP_LOAD, 1'b1, 16'h8000, 16'h0000, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'h7FFF, 16'hFFFF, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'hFFFF, 16'h5555, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'h0001, 16'hAAAA, 1'b0, 8'd0, 1'b0},
    // r = max: nothing exceeds, clamped to the last entry
    '{OP_DRAW, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd3, 1'b0},
    '{OP_DRAW, 1'b0, 16'hFFFF, 16'h0000, 1'b1, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h8000, 1'b0, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h7FFF, 1'b0, 8'd0, 1'b0},
    // leading zero weights, so the search has to skip entry 0 and 1
    '{OP_LOAD, 1'b1, 16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'h0000, 16'h0000, 1'b0, 8'd0, 1'b0},
    '{OP_LOAD, 1'b0, 16'h0003, 16'h0000, 1'b0, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h0001, 1'b0, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'd0, 1'b0},
    '{OP_DRAW, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 8'd2, 1'b0}
  };

  weighted_index_sampler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append |w| to the running sums; a first flag restarts the table,
  // a full table drops the load.
  function automatic void append_weight(logic [15:0] w, logic first);
    logic [16:0] mag;
    logic [24:0] sum;
    if (first) begin
      entry_cnt  = 0;
      weight_sum = '0;
    end
    if (entry_cnt >= TABLE_CAP) return;
    mag = w[15] ? (17'h10000 - {1'b0, w}) : {1'b0, w};
    sum = {1'b0, weight_sum} + {8'd0, mag};
    if (sum > 25'hFFFFFF) sum = 25'hFFFFFF;
    weight_sum           = sum[23:0];
    cum_sums[entry_cnt]  = sum[23:0];
    entry_cnt++;
  endfunction

  // Inverse-CDF pick, cross-multiplied: first entry with cum*RMAX > r*total; entry 0 wins ties.
  function automatic pick_t pick_index(logic [15:0] r);
    pick_t           p;
    longint unsigned target;
    int              lo;
    int              hi;
    int              mid;
    int              last;
    p.nt  = 1'b0;
    p.idx = '0;
    if (entry_cnt == 0) begin
      p.nt = 1'b1;
      return p;
    end
    target = 64'(r) * 64'(weight_sum);
    last   = entry_cnt - 1;
    if (weight_sum == 0) begin
      lo = (r == 0) ? 0 : last;
    end else if (target <= 64'(cum_sums[0]) * R_FULL) begin
      lo = 0;
    end else begin
      lo = 1;
      hi = entry_cnt;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (64'(cum_sums[mid]) * R_FULL > target) hi = mid;
        else lo = mid + 1;
      end
      if (lo > last) lo = last;
    end
    p.idx = lo[7:0];
    return p;
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3, 4: begin
        // small magnitudes give ties and equal sums
        if ($urandom_range(0, 1) != 0) return 16'($urandom_range(0, 4));
        else return -16'($urandom_range(1, 4));
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_rand();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Offer one item after a random gap, wait for the handshake, then update the
  // predictor. A typed expectation overrides the predicted one for draws.
  task automatic send_item(input logic op, input logic first, input logic [15:0] w,
                           input logic [15:0] r, input logic fixed_res = 1'b0,
                           input logic [7:0] idx = '0, input logic nt = 1'b0);
    int    gap;
    pick_t want;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 26) gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, w};
    in_tuser  <= {first, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == OP_LOAD) begin
      append_weight(w, first);
    end else begin
      want = fixed_res ? pick_t'{nt, idx} : pick_index(r);
      pending_picks.push_back(want);
    end
  endtask

  // Result side: check at each edge, then decide tready for the next cycle.
  initial begin
    pick_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_picks.size() == 0) begin
          flag_mismatch($sformatf("result idx=%0d nt=%0d with nothing pending",
                                  out_tdata, out_tuser[0]));
        end else begin
          want = pending_picks.pop_front();
          if (out_tuser[0] !== want.nt)
            flag_mismatch($sformatf("no_table %0b, want %0b", out_tuser[0], want.nt));
          if (out_tdata !== want.idx)
            flag_mismatch($sformatf("sample_index %0d, want %0d", out_tdata, want.idx));
        end
      end
      if (hold_req) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Stimulus
  initial begin
    int seq;
    int n_more;
    int n_draws;
    bit zero_tab;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].op, DIRECTED[i].first, DIRECTED[i].weight, DIRECTED[i].rnd,
                DIRECTED[i].fixed_res, DIRECTED[i].idx, DIRECTED[i].nt);
    end

    // One full table, plus a few loads past capacity that must be dropped.
    send_item(OP_LOAD, 1'b1, pick_weight(), 16'($urandom));
    repeat (TABLE_CAP + 3) send_item(OP_LOAD, 1'b0, pick_weight(), 16'($urandom));
    repeat (8) send_item(OP_DRAW, 1'($urandom), 16'($urandom), pick_rand());

    // Mostly small tables, each followed by a burst of draws.
    seq = 0;
    while (items_sent < $size(DIRECTED) + RAND_ITEMS) begin
      seq++;
      no_idle = (seq >= 40 && seq < 60);
      if (seq == 15) hold_req = 1'b1;   // receiver stalls long, block backs up
      zero_tab = ($urandom_range(0, 9) == 0);
      n_more   = (seq % 12 == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      // now and then keep growing the old table instead of starting a new one
      if ($urandom_range(0, 9) != 0)
        send_item(OP_LOAD, 1'b1, zero_tab ? 16'h0000 : pick_weight(), 16'($urandom));
      repeat (n_more) begin
        if ($urandom_range(0, 7) == 0)
          send_item(OP_DRAW, 1'($urandom), 16'($urandom), pick_rand());
        else
          send_item(OP_LOAD, 1'b0, zero_tab ? 16'h0000 : pick_weight(), 16'($urandom));
      end
      n_draws = (seq == 15) ? 8 : $urandom_range(1, 6);
      repeat (n_draws) send_item(OP_DRAW, 1'($urandom), 16'($urandom), pick_rand());
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    // room for a stray extra result to show up
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/wis_pkg.sv
rtl/weighted_index_sampler.sv
tb/sv/weighted_index_sampler_tb.sv
